>>> design/psfr_pkg.sv
`default_nettype none

package psfr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SEQ_W  = 32;

    typedef struct packed {
        logic [2:0]        sender;
        logic [SEQ_W-1:0]  packet_seq;
        logic [3:0]        word_count;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
        logic [WORD_W-1:0] word4;
        logic [WORD_W-1:0] word5;
        logic [WORD_W-1:0] word6;
        logic [WORD_W-1:0] word7;
    } item_t;

    typedef struct packed {
        logic [2:0]        out_sender;
        logic [WORD_W-1:0] out_word;
        logic              last;
        logic              all_received;
        logic              excess;
        logic              dropped;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_STORE,
        S_EMIT,
        S_ADV,
        S_CHECK,
        S_COUNT,
        S_RELEASE,
        S_FLUSH
    } state_t;

endpackage

`default_nettype wire

>>> design/per_sender_fifo_reorder_unit.sv
`default_nettype none

// Per-sender packet reorder unit.
// Input: a packet is taken at a clock edge with start high and busy low. Each
// packet carries a sender, a sequence number, a word count and up to eight words.
// Output: one transaction per delivered word, marked by result_valid for one
// cycle; the receiver cannot stall, so no back pressure exists. The final
// transaction caused by a packet has last set. A packet beyond the reorder
// window gives one transaction with dropped set.
// Configuration: cfg_we with cfg_wdata loads the count of expected words; write
// it only while busy is low.
// Timing: a stale, duplicate or out-of-range packet ends after the lookup, and
// a dropped packet after the lookup and a flush. An early packet is stored with
// one slot-memory write per word. An in-order packet emits its own words, then
// for each stored packet it releases checks the head slot, reads the count and
// emits the stored words; the single-port slot memory and the one shared sequence
// adder pace the unit at one word per cycle while it emits a packet's words. The
// last transaction is on the result ports in the first cycle with busy low.
// Reset: every sender expects sequence 1, all slots are empty and the expected
// count is zero.
module per_sender_fifo_reorder_unit
    import psfr_pkg::*;
#(
    parameter int SENDERS          = 8,
    parameter int WINDOW           = 8,
    parameter int WORDS_PER_PACKET = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire item_t             item,
    input  wire logic              cfg_we,
    input  wire logic [WORD_W-1:0] cfg_wdata,
    output logic                   result_valid,
    output result_t                result
);

    localparam int NSLOTS = SENDERS * WINDOW;
    localparam int SND_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int MOD_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int CNT_W  = $clog2(WORDS_PER_PACKET + 1);
    localparam int WI_W   = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
    localparam logic [6:0]       SENDERS_L = 7'(SENDERS);
    localparam logic [MOD_W:0]   WINDOW_M  = (MOD_W + 1)'(WINDOW);
    localparam logic [MOD_W-1:0] MOD_LAST  = MOD_W'(WINDOW - 1);
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1 % WINDOW);

    state_t state_reg, state_next;

    logic [2:0]        snd_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] pkt_reg [WORDS_PER_PACKET];

    logic [SEQ_W-1:0]  exp_reg [SENDERS];
    logic [MOD_W-1:0]  mod_reg [SENDERS];
    logic [NSLOTS-1:0] valid_reg;
    logic [WORD_W-1:0] remaining_reg;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rcnt_reg;
    logic [WORD_W-1:0] word_rd_reg;

    logic [CNT_W-1:0]  cnt_mem  [NSLOTS];
    logic [WORD_W-1:0] word_mem [NSLOTS][WORDS_PER_PACKET];

    logic    pend_valid_reg;
    result_t pend_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic              accept;
    logic [WORD_W-1:0] words_in [8];
    logic [CNT_W-1:0]  cnt_sat;
    logic [SND_W-1:0]  snd_idx;
    logic [SEQ_W-1:0]  cur_exp;
    logic [MOD_W-1:0]  cur_mod;
    logic              in_range;
    logic [SEQ_W:0]    diff;
    logic              stale;
    logic              far;
    logic [MOD_W:0]    pos_sum;
    logic [MOD_W:0]    pos_wrap;
    logic [SLOT_W-1:0] store_slot;
    logic [SLOT_W-1:0] head_slot;
    logic [CNT_W-1:0]  idx_inc;
    logic [WI_W-1:0]   widx;
    logic [SEQ_W-1:0]  exp_inc;
    logic [MOD_W-1:0]  mod_inc;

    logic              gen_word;
    logic              gen_drop;
    logic              gen;
    logic              flush;
    logic [WORD_W-1:0] gen_data;
    logic              store_go;
    logic              word_we;
    logic              adv;
    logic              head_take;
    logic              word_re;
    logic [WI_W-1:0]   rd_idx;
    result_t           gen_res;
    result_t           out_d;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SND_W-1:0] s,
                                                  input logic [MOD_W-1:0] p);
        int k;
        k = int'(s) * WINDOW + int'(p);
        return SLOT_W'(k);
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign words_in[0] = item.word0;
    assign words_in[1] = item.word1;
    assign words_in[2] = item.word2;
    assign words_in[3] = item.word3;
    assign words_in[4] = item.word4;
    assign words_in[5] = item.word5;
    assign words_in[6] = item.word6;
    assign words_in[7] = item.word7;

    assign cnt_sat = (item.word_count > 4'(WORDS_PER_PACKET)) ?
                     CNT_W'(WORDS_PER_PACKET) : CNT_W'(item.word_count);

    // Sequence lookup: one subtract gives both the stale test and the distance
    assign snd_idx  = SND_W'(snd_reg);
    assign cur_exp  = exp_reg[snd_idx];
    assign cur_mod  = mod_reg[snd_idx];
    assign in_range = ({4'b0, snd_reg} < SENDERS_L);
    assign diff     = {1'b0, seq_reg} - {1'b0, cur_exp};
    assign stale    = diff[SEQ_W];
    assign far      = (diff[SEQ_W-1:0] >= SEQ_W'(WINDOW));
    assign pos_sum  = {1'b0, cur_mod} + (MOD_W + 1)'(diff[SEQ_W-1:0]);
    assign pos_wrap = (pos_sum >= WINDOW_M) ? (pos_sum - WINDOW_M) : pos_sum;

    assign store_slot = slot_of(snd_idx, pos_wrap[MOD_W-1:0]);
    assign head_slot  = slot_of(snd_idx, cur_mod);

    assign idx_inc = idx_reg + CNT_W'(1);
    assign widx    = idx_reg[WI_W-1:0];

    // Slot position follows the expected number, restarting at zero on wrap
    assign exp_inc = cur_exp + SEQ_W'(1);
    assign mod_inc = ((cur_exp == '1) || (cur_mod == MOD_LAST)) ?
                     '0 : (cur_mod + MOD_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        gen_word   = 1'b0;
        gen_drop   = 1'b0;
        flush      = 1'b0;
        gen_data   = '0;
        store_go   = 1'b0;
        word_we    = 1'b0;
        adv        = 1'b0;
        head_take  = 1'b0;
        word_re    = 1'b0;
        rd_idx     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                idx_next = '0;
                if (!in_range || stale)
                begin
                    state_next = S_IDLE;
                end
                else if (far)
                begin
                    gen_drop   = 1'b1;
                    state_next = S_FLUSH;
                end
                else if (diff[SEQ_W-1:0] != '0)
                begin
                    // duplicates of a stored packet are dropped silently
                    if (valid_reg[store_slot])
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        store_go   = 1'b1;
                        slot_next  = store_slot;
                        state_next = (cnt_reg == '0) ? S_IDLE : S_STORE;
                    end
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? S_ADV : S_EMIT;
                end
            end
            S_STORE:
            begin
                word_we  = 1'b1;
                idx_next = idx_inc;
                if (idx_inc == cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                gen_word = 1'b1;
                gen_data = pkt_reg[widx];
                idx_next = idx_inc;
                if (idx_inc == cnt_reg)
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                adv        = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (valid_reg[head_slot])
                begin
                    head_take  = 1'b1;
                    slot_next  = head_slot;
                    state_next = S_COUNT;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_COUNT:
            begin
                // prefetch word 0 of the stored packet
                word_re    = 1'b1;
                rd_idx     = '0;
                idx_next   = CNT_W'(1);
                state_next = (rcnt_reg == '0) ? S_ADV : S_RELEASE;
            end
            S_RELEASE:
            begin
                gen_word = 1'b1;
                gen_data = word_rd_reg;
                if (idx_reg == rcnt_reg)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    word_re  = 1'b1;
                    rd_idx   = widx;
                    idx_next = idx_inc;
                end
            end
            S_FLUSH:
            begin
                flush      = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snd_reg <= item.sender;
            seq_reg <= item.packet_seq;
            cnt_reg <= cnt_sat;
            for (int i = 0; i < WORDS_PER_PACKET; i++)
            begin
                pkt_reg[i] <= words_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_go)
        begin
            cnt_mem[store_slot] <= cnt_reg;
        end
        if (word_we)
        begin
            word_mem[slot_reg][widx] <= pkt_reg[widx];
        end
        if (head_take)
        begin
            rcnt_reg <= cnt_mem[head_slot];
        end
        if (word_re)
        begin
            word_rd_reg <= word_mem[slot_reg][rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SENDERS; s++)
            begin
                exp_reg[s] <= SEQ_W'(1);
                mod_reg[s] <= MOD_RESET;
            end
            valid_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                exp_reg[snd_idx] <= exp_inc;
                mod_reg[snd_idx] <= mod_inc;
            end
            if (store_go)
            begin
                valid_reg[store_slot] <= 1'b1;
            end
            if (head_take)
            begin
                valid_reg[head_slot] <= 1'b0;
            end
        end
    end

    always_comb
    begin
        gen_res              = '0;
        gen_res.out_sender   = snd_reg;
        gen_res.out_word     = gen_data;
        gen_res.all_received = gen_word && (remaining_reg == WORD_W'(1));
        gen_res.excess       = gen_word && (remaining_reg == '0);
        gen_res.dropped      = gen_drop;
        out_d                = pend_reg;
        out_d.last           = flush;
    end

    assign gen = gen_word || gen_drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
        end
        else if (cfg_we)
        begin
            remaining_reg <= cfg_wdata;
        end
        else if (gen_word && (remaining_reg != '0))
        begin
            remaining_reg <= remaining_reg - WORD_W'(1);
        end
    end

    // Hold each result one step so the final one of a packet can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= pend_valid_reg && (gen || flush);
            if (gen)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            pend_reg <= gen_res;
        end
        if (pend_valid_reg && (gen || flush))
        begin
            out_reg <= out_d;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result transaction without a packet in progress");

    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.dropped) |-> (result.last && (result.out_word == '0)))
        else $error("drop transaction is not a lone zero-word result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.all_received && result.excess))
        else $error("all_received and excess both set");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind after packet completed");
`endif

endmodule

`default_nettype wire
